@@ rtl/intscan_pkg.sv @@
`timescale 1ns / 1ps

package intscan_pkg;

  localparam int CountWidthDef = 16;

  // register map: index i sits at byte address 8*i
  localparam int RegIdxW  = 3;
  localparam int PaddrW   = 6;
  localparam logic [RegIdxW-1:0] REG_SIGNED = 3'd0;
  localparam logic [RegIdxW-1:0] REG_BASE   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_SKIP   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_LIMIT  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_EXACT  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_RANGE  = 3'd5;
  localparam logic [RegIdxW-1:0] REG_MIN    = 3'd6;
  localparam logic [RegIdxW-1:0] REG_MAX    = 3'd7;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       begin_scan;
    logic       at_end;
  } in_item_t;

  typedef struct packed {
    logic        matched;
    logic [15:0] consumed;
    logic [15:0] value_start;
    logic [63:0] number_value;
  } out_item_t;

endpackage

@@ rtl/integer_token_scanner_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall    in_item  (in_item_t)
// out_      output     out_valid / out_stall  out_item (out_item_t)
// cfg       input      psel/penable/pwrite    paddr, pwdata, prdata
//
// One item per cycle unless out_stall holds a result back; items are staged,
// then each result is registered with out_valid. The per-byte multiply-add
// (64 x 6 bits) on the accumulator sets the cycle. Reset clears the scan
// state, staging and result valids, and loads the register defaults. An item
// yielding no result moves on even while out_stall holds a pending result.
module integer_token_scanner_top
  import intscan_pkg::*;
#(
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  typedef enum logic [1:0] {PH_IDLE, PH_LEAD, PH_DIGITS} phase_t;

  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  function automatic logic [6:0] digit_code(input logic [7:0] c);
    logic [7:0] d;
    logic       ok;
    d  = 8'd0;
    ok = 1'b0;
    if (c >= CH_0 && c <= CH_9) begin
      d  = c - CH_0;
      ok = 1'b1;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d  = c - CH_UA + 8'd10;
      ok = 1'b1;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d  = c - CH_LA + 8'd10;
      ok = 1'b1;
    end
    return {ok, d[5:0]};
  endfunction

  // configuration registers
  logic        sgn_r;
  logic [5:0]  base_r;
  logic        skip_r;
  logic [7:0]  limit_r;
  logic [7:0]  exact_r;
  logic [1:0]  range_r;
  logic [63:0] min_r;
  logic [63:0] max_r;

  logic                 cfg_wr;
  logic [RegIdxW-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PaddrW-1:PaddrW-RegIdxW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sgn_r   <= 1'b1;
      base_r  <= 6'd10;
      skip_r  <= 1'b0;
      limit_r <= 8'd0;
      exact_r <= 8'd0;
      range_r <= 2'd0;
      min_r   <= 64'd0;
      max_r   <= 64'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SIGNED: sgn_r   <= pwdata[0];
        REG_BASE:   base_r  <= pwdata[5:0];
        REG_SKIP:   skip_r  <= pwdata[0];
        REG_LIMIT:  limit_r <= pwdata[7:0];
        REG_EXACT:  exact_r <= pwdata[7:0];
        REG_RANGE:  range_r <= pwdata[1:0];
        REG_MIN:    min_r   <= pwdata;
        REG_MAX:    max_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SIGNED: prdata = {63'd0, sgn_r};
      REG_BASE:   prdata = {58'd0, base_r};
      REG_SKIP:   prdata = {63'd0, skip_r};
      REG_LIMIT:  prdata = {56'd0, limit_r};
      REG_EXACT:  prdata = {56'd0, exact_r};
      REG_RANGE:  prdata = {62'd0, range_r};
      REG_MIN:    prdata = min_r;
      REG_MAX:    prdata = max_r;
      default:    prdata = 64'd0;
    endcase
  end

  // input staging and scan state
  logic                   s1_valid_r;
  in_item_t               s1_item_r;
  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [COUNT_WIDTH-1:0] space_cnt_r, space_cnt_nxt;
  logic [COUNT_WIDTH-1:0] digit_cnt_r, digit_cnt_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   neg_r, neg_nxt;
  logic                   sat_r, sat_nxt;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  // current scan view: begin_scan clears everything
  phase_t                 cur_phase;
  logic [COUNT_WIDTH-1:0] cur_byte, cur_space, cur_digit;
  logic [COUNT_WIDTH-1:0] byte_inc, space_inc, digit_inc;
  logic [63:0]            cur_acc;
  logic                   cur_ovf, cur_neg, cur_sat;
  logic [7:0]             ch;
  logic [6:0]             dcode;
  logic                   is_space, is_sign, digit_ok, limit_hit;
  logic [69:0]            mac;
  logic                   emit, advance;

  // finish logic
  logic        ok;
  logic [63:0] value_u, value_s;
  logic        exact_bad, lim_bad, umin_bad, umax_bad, smin_bad, smax_bad;
  logic [31:0] byte_w, space_w;
  out_item_t   res;

  always_comb begin
    ch        = s1_item_r.text_byte;
    cur_phase = s1_item_r.begin_scan ? PH_LEAD : phase_r;
    cur_byte  = s1_item_r.begin_scan ? '0 : byte_cnt_r;
    cur_space = s1_item_r.begin_scan ? '0 : space_cnt_r;
    cur_digit = s1_item_r.begin_scan ? '0 : digit_cnt_r;
    cur_acc   = s1_item_r.begin_scan ? 64'd0 : acc_r;
    cur_ovf   = s1_item_r.begin_scan ? 1'b0 : ovf_r;
    cur_neg   = s1_item_r.begin_scan ? 1'b0 : neg_r;
    cur_sat   = s1_item_r.begin_scan ? 1'b0 : sat_r;

    byte_inc  = (cur_byte == CntMax) ? cur_byte : cur_byte + 1'b1;
    space_inc = (cur_space == CntMax) ? cur_space : cur_space + 1'b1;
    digit_inc = (cur_digit == CntMax) ? cur_digit : cur_digit + 1'b1;

    is_space  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    is_sign   = (ch == CH_MINUS) || (ch == CH_PLUS);
    dcode     = digit_code(ch);
    digit_ok  = dcode[6] && (dcode[5:0] < base_r);
    limit_hit = (limit_r != 8'd0) && (32'(cur_digit) >= 32'(limit_r));
    mac       = 70'(cur_acc) * 70'(base_r) + 70'(dcode[5:0]);

    phase_nxt     = cur_phase;
    byte_cnt_nxt  = cur_byte;
    space_cnt_nxt = cur_space;
    digit_cnt_nxt = cur_digit;
    acc_nxt       = cur_acc;
    ovf_nxt       = cur_ovf;
    neg_nxt       = cur_neg;
    sat_nxt       = cur_sat;
    emit          = 1'b0;

    case (cur_phase)
      PH_IDLE: ;
      PH_LEAD, PH_DIGITS: begin
        if (s1_item_r.at_end) begin
          emit      = 1'b1;
          phase_nxt = PH_IDLE;
        end else if (cur_phase == PH_LEAD && skip_r && is_space) begin
          byte_cnt_nxt  = byte_inc;
          space_cnt_nxt = space_inc;
          sat_nxt       = cur_sat || (cur_byte == CntMax) || (cur_space == CntMax);
        end else if (cur_phase == PH_LEAD && sgn_r && is_sign) begin
          phase_nxt    = PH_DIGITS;
          neg_nxt      = (ch == CH_MINUS);
          byte_cnt_nxt = byte_inc;
          sat_nxt      = cur_sat || (cur_byte == CntMax);
        end else if (!digit_ok || limit_hit) begin
          emit      = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt     = PH_DIGITS;
          // hold the accumulator when the multiply-add no longer fits in 64 bits
          if (mac[69:64] != 6'd0) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = mac[63:0];
          end
          byte_cnt_nxt  = byte_inc;
          digit_cnt_nxt = digit_inc;
          sat_nxt       = cur_sat || (cur_byte == CntMax) || (cur_digit == CntMax);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    value_u   = cur_acc;
    value_s   = cur_neg ? (64'd0 - cur_acc) : cur_acc;
    exact_bad = (exact_r != 8'd0) && (32'(cur_digit) != 32'(exact_r));
    lim_bad   = cur_acc[63] && !(cur_neg && cur_acc[62:0] == 63'd0);
    umin_bad  = range_r[0] && !min_r[63] && (min_r != 64'd0) && (cur_acc < min_r);
    umax_bad  = range_r[1] && (max_r[63] || (cur_acc > max_r));
    smin_bad  = range_r[0] && ($signed(value_s) < $signed(min_r));
    smax_bad  = range_r[1] && ($signed(max_r) < $signed(value_s));
    ok = (cur_digit != '0) && !cur_ovf && !cur_sat && !exact_bad;
    if (sgn_r) begin
      ok = ok && !lim_bad && !smin_bad && !smax_bad;
    end else begin
      ok = ok && !umin_bad && !umax_bad;
    end
    byte_w  = 32'(cur_byte);
    space_w = 32'(cur_space);
    res.matched      = ok;
    res.consumed     = ok ? byte_w[15:0] : 16'd0;
    res.value_start  = ok ? space_w[15:0] : 16'd0;
    res.number_value = ok ? (sgn_r ? value_s : value_u) : 64'd0;
  end

  // an item with no result never waits on the output side
  assign advance  = s1_valid_r && (!emit || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_IDLE;
      byte_cnt_r  <= '0;
      space_cnt_r <= '0;
      digit_cnt_r <= '0;
      acc_r       <= 64'd0;
      ovf_r       <= 1'b0;
      neg_r       <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        phase_r     <= phase_nxt;
        byte_cnt_r  <= byte_cnt_nxt;
        space_cnt_r <= space_cnt_nxt;
        digit_cnt_r <= digit_cnt_nxt;
        acc_r       <= acc_nxt;
        ovf_r       <= ovf_nxt;
        neg_r       <= neg_nxt;
        sat_r       <= sat_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    if (advance && emit) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/intscan_checker.sv @@
`timescale 1ns / 1ps

module intscan_checker
  import intscan_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // a failed scan reports all-zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.matched |->
      out_item.consumed == 16'd0 && out_item.value_start == 16'd0 &&
      out_item.number_value == 64'd0)
    else $error("failed result carries nonzero fields");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled with output free");

  // reset drops any pending result
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind integer_token_scanner_top intscan_checker u_intscan_checker (.*);
